[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared implication forms for the concurrent checks of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("concurrent check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("concurrent check failed");

`endif

[rtl/rhd_pkg.sv]
// ----------------------------------------------------------------------------
// rhd_pkg
// Constants and types of the 2x2 box downscaler.
// ----------------------------------------------------------------------------
package rhd_pkg;

	// Largest output row length the line store holds.
	localparam int MAX_OUT_WIDTH = 1024;

	localparam int CHAN_W = 8;
	localparam int PAIR_W = CHAN_W + 1;
	localparam int NUM_CH = 3;
	localparam int PIX_W  = NUM_CH * CHAN_W;
	localparam int LINE_W = NUM_CH * PAIR_W;
	localparam int CFG_W  = 11;

	// Line store index, source column count, effective width.
	localparam int IDX_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int COL_W = $clog2(2 * MAX_OUT_WIDTH);
	localparam int WID_W = $clog2(MAX_OUT_WIDTH + 1);
	localparam int CNT_W = ((COL_W > WID_W) ? COL_W : WID_W) + 1;

	// One output pixel with its end-of-row mark.
	typedef struct packed {
		logic              last_in_row;
		logic [CHAN_W-1:0] chan2;
		logic [CHAN_W-1:0] chan1;
		logic [CHAN_W-1:0] chan0;
	} result_t;

endpackage

[rtl/rhd_ram.sv]
// ----------------------------------------------------------------------------
// rhd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rhd_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 27
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/rhd_outbuf.sv]
// ----------------------------------------------------------------------------
// rhd_outbuf
// Output register with a skid stage; ready toward the datapath is registered.
// ----------------------------------------------------------------------------
module rhd_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rhd_pkg::result_t push_data,
	output logic             space,
	output logic             out_valid,
	input  logic             out_ready,
	output rhd_pkg::result_t out_data
);
	import rhd_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    load;

	// Output register may load when empty or being drained
	assign load = !out_valid_q || out_ready;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: skid entry goes first, it is older than any new push
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/rgb_half_downscale_box2x2_core.sv]
// ----------------------------------------------------------------------------
// rgb_half_downscale_box2x2_core
// Halves an RGB888 raster in both directions with a rounded 2x2 box average.
//
//  channel  | direction | data                               | side bits
//  ---------+-----------+------------------------------------+----------------
//  s_*      | in        | tdata: chan0, chan1, chan2 (24 b)  | tuser: frame_start
//  m_*      | out       | tdata: chan0, chan1, chan2 (24 b)  | tlast: last_in_row
//  cfg_*    | in        | out_width (11 b)                   | -
//
// One source pixel per cycle while s_tready is high; an odd-row odd-column
// pixel's output is registered in the output stage, or the skid stage if stalled.
// The line store read is issued with the even-column pixel, so its registered
// read data is ready before the partner pixel can arrive.
// s_tready drops only while both output stages hold a pixel.
// Reset clears counters and the output stages; the line store is not cleared.
// ----------------------------------------------------------------------------
module rgb_half_downscale_box2x2_core (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	input  logic [rhd_pkg::PIX_W-1:0]                     s_tdata, // chan0, chan1, chan2
	input  logic                                          s_tuser, // frame_start
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	output logic [rhd_pkg::PIX_W-1:0]                     m_tdata, // chan0, chan1, chan2
	output logic                                          m_tlast,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [rhd_pkg::CFG_W-1:0]                     cfg_data
);
	import rhd_pkg::*;

	logic [WID_W-1:0]  width_q;
	logic [COL_W-1:0]  col_q;
	logic              odd_q;
	logic [PIX_W-1:0]  held_q;

	logic              s_xfer;
	logic [WID_W-1:0]  width_cfg;
	logic [CNT_W-1:0]  twice_w;
	logic [CNT_W-1:0]  col_start;
	logic [CNT_W-1:0]  col_inc;
	logic              odd_start;
	logic [IDX_W-1:0]  idx;
	logic              col_odd;
	logic [LINE_W-1:0] pair_word;
	logic [LINE_W-1:0] above_word;
	logic              mem_we;
	logic              mem_re;
	logic              push;
	logic              space;
	result_t           res;
	result_t           out_res;
	logic [CHAN_W-1:0] avg [NUM_CH];

	assign s_xfer    = s_tvalid && s_tready;
	assign s_tready  = space;
	assign cfg_ready = 1'b1;

	// Clamp the written width into one to MAX_OUT_WIDTH
	always_comb begin
		if (cfg_data == '0) begin
			width_cfg = WID_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_OUT_WIDTH)) begin
			width_cfg = WID_W'(MAX_OUT_WIDTH);
		end else begin
			width_cfg = WID_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WID_W'(1);
		end else if (cfg_valid) begin
			width_q <= width_cfg;
		end
	end

	// Position of this pixel: frame restart, then wrap if width shrank
	always_comb begin
		twice_w   = CNT_W'(width_q) << 1;
		col_start = s_tuser ? '0 : CNT_W'(col_q);
		odd_start = s_tuser ? 1'b0 : odd_q;
		if (col_start >= twice_w) begin
			col_start = '0;
		end
		idx     = col_start[IDX_W:1];
		col_odd = col_start[0];
		col_inc = col_start + CNT_W'(1);
	end

	// Advance column and row parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
		end else if (s_xfer) begin
			if (col_inc >= twice_w) begin
				col_q <= '0;
				odd_q <= !odd_start;
			end else begin
				col_q <= COL_W'(col_inc);
				odd_q <= odd_start;
			end
		end
	end

	// Hold the even-column pixel for its partner
	always_ff @(posedge clk) begin
		if (s_xfer && !col_odd) begin
			held_q <= s_tdata;
		end
	end

	// Pair sums and rounded 2x2 averages per channel
	always_comb begin
		logic [PAIR_W-1:0] pair;
		logic [PAIR_W-1:0] above;
		logic [PAIR_W:0]   total;
		pair_word = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			pair  = PAIR_W'(held_q[c*CHAN_W +: CHAN_W]) + PAIR_W'(s_tdata[c*CHAN_W +: CHAN_W]);
			above = above_word[c*PAIR_W +: PAIR_W];
			total = (PAIR_W+1)'(above) + (PAIR_W+1)'(pair) + (PAIR_W+1)'(2);
			pair_word[c*PAIR_W +: PAIR_W] = pair;
			avg[c] = total[PAIR_W:2];
		end
	end

	// Even rows store pair sums; even columns prefetch the entry above
	assign mem_we = s_xfer && col_odd && !odd_start;
	assign mem_re = s_xfer && !col_odd;

	rhd_ram #(
		.DEPTH (MAX_OUT_WIDTH),
		.WIDTH (LINE_W)
	) u_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx),
		.wdata (pair_word),
		.re    (mem_re),
		.raddr (idx),
		.rdata (above_word)
	);

	// Odd rows emit one pixel per source pair
	assign push            = s_xfer && col_odd && odd_start;
	assign res.chan0       = avg[0];
	assign res.chan1       = avg[1];
	assign res.chan2       = avg[2];
	assign res.last_in_row = (WID_W'(idx) == (width_q - WID_W'(1)));

	rhd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {out_res.chan2, out_res.chan1, out_res.chan0};
	assign m_tlast = out_res.last_in_row;

endmodule

[rtl/rhd_checker.sv]
// ----------------------------------------------------------------------------
// rhd_checker
// Port-level checks of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// Hold a stalled output
	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`CHK_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

	// Input backpressure only while the output side is full
	`CHK_IMPLY(a_bp_cause, clk, arst_n, !s_tready, m_tvalid)

	// An output appears only right after an input transfer
	`CHK_IMPLY(a_out_origin, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready))

endmodule

bind rgb_half_downscale_box2x2_core rhd_checker u_rhd_checker (.*);
